/* rtl/gng_pkg.sv */
// shared types, constants and helpers of the grid negative gradient block
// no dependencies

package gng_pkg;

  // grid and sample geometry
  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int SAMPLE_W  = 24;
  localparam int COORD_W   = 10;
  localparam int CNT_W     = 11;
  localparam int STEP_W    = 16;
  localparam int FIELD_W   = 32;
  localparam int FRAC_BITS = 12;

  // datapath widths: one extra bit for a difference, signed step operand
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + STEP_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COL_COUNT    = 2'd1,
    CFG_INV_ROW_STEP = 2'd2,
    CFG_INV_COL_STEP = 2'd3
  } cfg_idx_e;

  localparam logic [STEP_W-1:0] INV_STEP_RESET = STEP_W'(1 << FRAC_BITS);

  // line buffer view of the cell under the incoming sample
  typedef struct packed {
    logic [SAMPLE_W-1:0] wm1;      // previous row, column c-1
    logic [SAMPLE_W-1:0] w0;       // previous row, column c
    logic [SAMPLE_W-1:0] wp1;      // previous row, column c+1
    logic [SAMPLE_W-1:0] o0;       // row before that, column c
    logic [SAMPLE_W-1:0] r0;       // last sample of this row
    logic [SAMPLE_W-1:0] r1;       // sample before that
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                row_last;
    logic                col_last;
  } win_t;

  // operands of one result
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic                     cx;    // central difference along rows
    logic signed [DIFF_W-1:0] dy;
    logic                     cy;    // central difference along columns
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic                     done;
  } res_op_t;

  // signed difference of two samples, one bit wider
  function automatic logic signed [DIFF_W-1:0] sdiff(logic [SAMPLE_W-1:0] a,
                                                     logic [SAMPLE_W-1:0] b);
    return $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
  endfunction

  // count register clamped to [2, hi], returned as its last index
  function automatic logic [COORD_W-1:0] count_last(logic [CNT_W-1:0] v,
                                                     logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] lim;
    if (v < CNT_W'(2)) begin
      lim = CNT_W'(2);
    end else if (v > hi) begin
      lim = hi;
    end else begin
      lim = v;
    end
    return COORD_W'(lim - CNT_W'(1));
  endfunction

endpackage

/* rtl/gng_window.sv */
// line buffers: two row memories, three-column window, grid position tracking
// depends on gng_pkg

module gng_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          restart_i,
  input  logic [gng_pkg::SAMPLE_W-1:0]  cur_i,
  input  logic [gng_pkg::COORD_W-1:0]   rows_last_i,
  input  logic [gng_pkg::COORD_W-1:0]   cols_last_i,
  output logic                          ready_o,
  output gng_pkg::win_t                 win_o
);
  import gng_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_WRITE = 3'b010,
    ST_FILL  = 3'b100
  } lb_state_e;

  localparam logic [1:0] FILL_LAST = 2'd2;

  lb_state_e state_q, state_d;
  logic [1:0] fill_cnt_q, fill_cnt_d;

  logic [COORD_W-1:0] in_row_q, in_col_q;
  logic [SAMPLE_W-1:0] r0_q, r1_q;

  logic [SAMPLE_W-1:0] mem_new [MAX_COLS];
  logic [SAMPLE_W-1:0] mem_old [MAX_COLS];
  logic [SAMPLE_W-1:0] nr_q, or_q, w0_q, wm1_q;

  logic [COORD_W-1:0]  pend_addr_q;
  logic [SAMPLE_W-1:0] pend_new_q, pend_old_q;

  logic [COORD_W-1:0] row, col;
  logic row_last, col_last;

  logic rd_en, wr_en;
  logic [COORD_W-1:0] rd_new_addr, rd_old_addr, wr_addr;
  logic [SAMPLE_W-1:0] wr_new, wr_old;

  // clamped position of the incoming sample
  always_comb begin
    row      = (in_row_q < rows_last_i) ? in_row_q : rows_last_i;
    col      = (in_col_q < cols_last_i) ? in_col_q : cols_last_i;
    row_last = (row == rows_last_i);
    col_last = (col == cols_last_i);
  end

  // window reload sequencing
  always_comb begin
    state_d    = state_q;
    fill_cnt_d = fill_cnt_q;
    unique case (state_q)
      ST_RUN: begin
        if (restart_i) begin
          state_d    = ST_FILL;
          fill_cnt_d = '0;
        end else if (accept_i && col_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d    = ST_FILL;
        fill_cnt_d = '0;
      end
      ST_FILL: begin
        if (restart_i) begin
          fill_cnt_d = '0;
        end else if (fill_cnt_q == FILL_LAST) begin
          state_d = ST_RUN;
        end else begin
          fill_cnt_d = fill_cnt_q + 2'd1;
        end
      end
      default: begin
        state_d    = ST_FILL;
        fill_cnt_d = '0;
      end
    endcase
  end

  // memory port control: reads run ahead of the window, writes trail by a column
  always_comb begin
    rd_en = (state_q == ST_FILL) || (accept_i && !col_last);
    if (state_q == ST_FILL) begin
      rd_new_addr = col + COORD_W'(fill_cnt_q) - COORD_W'(1);
      rd_old_addr = col;
    end else begin
      rd_new_addr = col + COORD_W'(2);
      rd_old_addr = col + COORD_W'(1);
    end
    wr_en = (state_q == ST_WRITE) || (accept_i && (col != '0));
    if (state_q == ST_WRITE) begin
      wr_addr = pend_addr_q;
      wr_new  = pend_new_q;
      wr_old  = pend_old_q;
    end else begin
      wr_addr = col - COORD_W'(1);
      wr_new  = r0_q;
      wr_old  = wm1_q;
    end
  end

  // control state and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_cnt_q <= '0;
      in_row_q   <= '0;
      in_col_q   <= '0;
      r0_q       <= '0;
      r1_q       <= '0;
    end else begin
      state_q    <= state_d;
      fill_cnt_q <= fill_cnt_d;
      if (accept_i) begin
        r1_q <= r0_q;
        r0_q <= cur_i;
        if (col_last) begin
          in_col_q <= '0;
          in_row_q <= row_last ? '0 : row + COORD_W'(1);
        end else begin
          in_col_q <= col + COORD_W'(1);
          in_row_q <= row;
        end
      end
    end
  end

  // row memories and window registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_new[wr_addr] <= wr_new;
      mem_old[wr_addr] <= wr_old;
    end
    if (rd_en) begin
      nr_q  <= mem_new[rd_new_addr];
      or_q  <= mem_old[rd_old_addr];
      w0_q  <= nr_q;
      wm1_q <= w0_q;
    end
    if (accept_i && col_last) begin
      pend_addr_q <= col;
      pend_new_q  <= cur_i;
      pend_old_q  <= w0_q;
    end
  end

  assign ready_o = (state_q == ST_RUN);

  always_comb begin
    win_o.wm1      = wm1_q;
    win_o.w0       = w0_q;
    win_o.wp1      = nr_q;
    win_o.o0       = or_q;
    win_o.r0       = r0_q;
    win_o.r1       = r1_q;
    win_o.row      = row;
    win_o.col      = col;
    win_o.row_last = row_last;
    win_o.col_last = col_last;
  end

endmodule

/* rtl/gng_job.sv */
// operand selection for the up to three results of one sample, issued one a cycle while take_i is high
// depends on gng_pkg

module gng_job (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [gng_pkg::SAMPLE_W-1:0]  cur_i,
  input  gng_pkg::win_t                 win_i,
  input  logic                          take_i,
  output logic                          valid_o,
  output gng_pkg::res_op_t              op_o,
  output logic                          free_o
);
  import gng_pkg::*;

  res_op_t cand [3];
  res_op_t ops_q [3];
  logic [2:0] pend_q, mask_new, sel, rem;
  logic nz_row, row_one, c0, c1;

  // operand candidates for the cell above, the trailing final-row cell and the corner
  always_comb begin
    nz_row  = (win_i.row != '0);
    row_one = (win_i.row == COORD_W'(1));
    c0      = (win_i.col == '0);
    c1      = (win_i.col == COORD_W'(1));

    // cell one row above
    cand[0].dx = row_one ? sdiff(cur_i, win_i.w0) : sdiff(cur_i, win_i.o0);
    cand[0].cx = !row_one;
    priority if (c0) begin
      cand[0].dy = sdiff(win_i.wp1, win_i.w0);
      cand[0].cy = 1'b0;
    end else if (win_i.col_last) begin
      cand[0].dy = sdiff(win_i.w0, win_i.wm1);
      cand[0].cy = 1'b0;
    end else begin
      cand[0].dy = sdiff(win_i.wp1, win_i.wm1);
      cand[0].cy = 1'b1;
    end
    cand[0].row  = win_i.row - COORD_W'(1);
    cand[0].col  = win_i.col;
    cand[0].done = 1'b0;

    // final row, one column behind
    cand[1].dx   = sdiff(win_i.r0, win_i.wm1);
    cand[1].cx   = 1'b0;
    cand[1].dy   = c1 ? sdiff(cur_i, win_i.r0) : sdiff(cur_i, win_i.r1);
    cand[1].cy   = !c1;
    cand[1].row  = win_i.row;
    cand[1].col  = win_i.col - COORD_W'(1);
    cand[1].done = 1'b0;

    // last cell of the grid
    cand[2].dx   = sdiff(cur_i, win_i.w0);
    cand[2].cx   = 1'b0;
    cand[2].dy   = sdiff(cur_i, win_i.r0);
    cand[2].cy   = 1'b0;
    cand[2].row  = win_i.row;
    cand[2].col  = win_i.col;
    cand[2].done = 1'b1;

    mask_new = {win_i.row_last & win_i.col_last, win_i.row_last & !c0, nz_row};
  end

  // oldest pending result goes first
  always_comb begin
    priority if (pend_q[0]) begin
      sel  = 3'b001;
      op_o = ops_q[0];
    end else if (pend_q[1]) begin
      sel  = 3'b010;
      op_o = ops_q[1];
    end else begin
      sel  = {pend_q[2], 2'b00};
      op_o = ops_q[2];
    end
    rem     = take_i ? (pend_q & ~sel) : pend_q;
    valid_o = (pend_q != '0);
    free_o  = (rem == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (accept_i) begin
      pend_q <= mask_new;
    end else begin
      pend_q <= rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ops_q <= cand;
    end
  end

endmodule

/* rtl/gng_scale.sv */
// step scaling: multiply by reciprocal step, floor shift, negate, saturate, output register
// depends on gng_pkg

module gng_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  gng_pkg::res_op_t                    op_i,
  input  logic [gng_pkg::STEP_W-1:0]          inv_row_i,
  input  logic [gng_pkg::STEP_W-1:0]          inv_col_i,
  output logic                                take_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gng_pkg::FIELD_W-1:0]  field_x_o,
  output logic signed [gng_pkg::FIELD_W-1:0]  field_y_o,
  output logic [gng_pkg::COORD_W-1:0]         cell_row_o,
  output logic [gng_pkg::COORD_W-1:0]         cell_col_o,
  output logic                                clipped_o,
  output logic                                frame_done_o
);
  import gng_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               clip;
  } sat_t;

  localparam logic signed [PROD_W:0] SAT_HI =
    {{(PROD_W + 2 - FIELD_W){1'b0}}, {(FIELD_W - 1){1'b1}}};
  localparam logic signed [PROD_W:0] SAT_LO = ~SAT_HI;

  // -(p >> s) with floor shift, clamped to the field range
  function automatic sat_t neg_sat(logic signed [PROD_W-1:0] p, logic central);
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W:0]   n;
    sat_t res;
    q = central ? (p >>> (FRAC_BITS + 1)) : (p >>> FRAC_BITS);
    n = -((PROD_W + 1)'(q));
    if (n > SAT_HI) begin
      res.value = SAT_HI[FIELD_W-1:0];
      res.clip  = 1'b1;
    end else if (n < SAT_LO) begin
      res.value = SAT_LO[FIELD_W-1:0];
      res.clip  = 1'b1;
    end else begin
      res.value = n[FIELD_W-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

  logic m_valid_q, out_valid_q, out_ready;
  logic signed [PROD_W-1:0] px, py, px_q, py_q;
  logic signed [STEP_W:0]   inv_row_s, inv_col_s;
  logic cx_q, cy_q, done_q;
  logic [COORD_W-1:0] row_q, col_q;
  sat_t sx, sy;

  // handshake of the two stages
  assign out_ready = !out_valid_q || !out_stall_i;
  assign take_o    = valid_i && (!m_valid_q || out_ready);

  // product stage
  always_comb begin
    inv_row_s = $signed({1'b0, inv_row_i});
    inv_col_s = $signed({1'b0, inv_col_i});
    px        = op_i.dx * inv_row_s;
    py        = op_i.dy * inv_col_s;
  end

  // shift and saturate stage
  always_comb begin
    sx = neg_sat(px_q, cx_q);
    sy = neg_sat(py_q, cy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        m_valid_q <= 1'b1;
      end else if (out_ready) begin
        m_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      px_q   <= px;
      py_q   <= py;
      cx_q   <= op_i.cx;
      cy_q   <= op_i.cy;
      row_q  <= op_i.row;
      col_q  <= op_i.col;
      done_q <= op_i.done;
    end
    if (out_ready && m_valid_q) begin
      field_x_o    <= sx.value;
      field_y_o    <= sy.value;
      cell_row_o   <= row_q;
      cell_col_o   <= col_q;
      clipped_o    <= sx.clip | sy.clip;
      frame_done_o <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/grid_negative_gradient.sv */
// Streaming negative gradient of a 2D potential grid, raster input, column fastest.
// Operands of an accepted sample are registered, then its products, then the output register.
// Unless stalled, later results of a sample follow one a cycle and input takes 1 sample/cycle;
// a final-row sample past column 0 waits until its results are taken, a row's last sample also
// on a trailing buffer write and window reload reads. Reset: position 0/0, counts 1024, steps
// 1.0; window reload after reset and each config write; row buffers undefined until written.

module grid_negative_gradient (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gng_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gng_pkg::STEP_W-1:0]          cfg_data_i,
  // sample requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gng_pkg::SAMPLE_W-1:0] potential_i,
  // result requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gng_pkg::FIELD_W-1:0]  field_x_o,
  output logic signed [gng_pkg::FIELD_W-1:0]  field_y_o,
  output logic [gng_pkg::COORD_W-1:0]         cell_row_o,
  output logic [gng_pkg::COORD_W-1:0]         cell_col_o,
  output logic                                clipped_o,
  output logic                                frame_done_o
);
  import gng_pkg::*;

  logic [COORD_W-1:0] rows_last_q, cols_last_q;
  logic [STEP_W-1:0]  inv_row_q, inv_col_q;
  logic cfg_wr, win_ready, job_free, job_valid, take, accept;
  win_t    win;
  res_op_t job_op;

  // configuration registers, counts kept as clamped last index
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= COORD_W'(MAX_ROWS - 1);
      cols_last_q <= COORD_W'(MAX_COLS - 1);
      inv_row_q   <= INV_STEP_RESET;
      inv_col_q   <= INV_STEP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_COUNT:
          rows_last_q <= count_last(cfg_data_i[CNT_W-1:0], CNT_W'(MAX_ROWS));
        CFG_COL_COUNT:
          cols_last_q <= count_last(cfg_data_i[CNT_W-1:0], CNT_W'(MAX_COLS));
        CFG_INV_ROW_STEP: inv_row_q <= cfg_data_i;
        CFG_INV_COL_STEP: inv_col_q <= cfg_data_i;
      endcase
    end
  end

  // input request handshake
  assign in_stall_o = !(win_ready && job_free);
  assign accept     = in_valid_i && !in_stall_o;

  gng_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .restart_i   (cfg_wr),
    .cur_i       (potential_i),
    .rows_last_i (rows_last_q),
    .cols_last_i (cols_last_q),
    .ready_o     (win_ready),
    .win_o       (win)
  );

  gng_job u_job (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cur_i    (potential_i),
    .win_i    (win),
    .take_i   (take),
    .valid_o  (job_valid),
    .op_o     (job_op),
    .free_o   (job_free)
  );

  gng_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (job_valid),
    .op_i         (job_op),
    .inv_row_i    (inv_row_q),
    .inv_col_i    (inv_col_q),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .field_x_o    (field_x_o),
    .field_y_o    (field_y_o),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .clipped_o    (clipped_o),
    .frame_done_o (frame_done_o)
  );

endmodule
